// ===== hw/rtl/lruc_pkg.sv =====
// shared constants, types and field layout for the lru id cache
package lruc_pkg;

    // storage geometry
    localparam int MAX_ENTRIES = 16;
    localparam int ID_WIDTH    = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

    // configuration register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // fixed field widths of the stream payloads
    localparam int REQ_W     = 16;
    localparam int RANK_W    = 4;
    localparam int EVID_W    = 16;

    // input beat layout
    localparam int IN_TDATA_W = ((REQ_W + 7) / 8) * 8;

    // output beat layout, lowest bit first
    localparam int HIT_BIT    = 0;
    localparam int RANK_LSB   = HIT_BIT + 1;
    localparam int EVV_BIT    = RANK_LSB + RANK_W;
    localparam int EVID_LSB   = EVV_BIT + 1;
    localparam int OUT_W      = EVID_LSB + EVID_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;   // capture compare result this cycle
        logic valid;    // cell holds a live entry
        logic load;     // take the neighbor's id
    } cell_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/lruc_cell.sv =====
// one rank of the recency stack: id storage, compare and first-hit chain link
module lruc_cell (
    input  logic                          clk,
    input  lruc_pkg::cell_ctrl_t          ctrl,
    input  logic [lruc_pkg::ID_WIDTH-1:0] req_id,
    input  logic [lruc_pkg::ID_WIDTH-1:0] shift_in,
    input  logic                          found_in,
    output logic [lruc_pkg::ID_WIDTH-1:0] id,
    output logic                          found_out,
    output logic                          first
);

    logic [lruc_pkg::ID_WIDTH-1:0] id_reg;
    logic [lruc_pkg::ID_WIDTH-1:0] id_next;
    logic                          match_reg;
    logic                          match_next;

    // next id and compare result
    always_comb
    begin
        id_next    = ctrl.load ? shift_in : id_reg;
        match_next = ctrl.cmp_en ? (ctrl.valid && (id_reg == req_id)) : match_reg;
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        match_reg <= match_next;
    end

    // first match wins down the row
    assign first     = match_reg & ~found_in;
    assign found_out = match_reg | found_in;
    assign id        = id_reg;

endmodule

// ===== hw/rtl/lru_id_cache.sv =====
// top level of the lru id cache: sequencer, capacity register and cell row
//
// Fully associative LRU cache of record ids, one request beat in and one
// result beat out per request.
//   s_tdata : req_id [15:0]
//   m_tdata : hit [0], hit_rank [4:1], evict_valid [5], evict_id [21:6]
//   cfg_we / cfg_wdata : capacity, 1 to 16 (0 acts as 1, above 16 as 16)
// A request steps through accept, compare in every cell of the stack, then
// rank select and one shift of the stack toward the least recent end. The
// result is registered and shows on m_tvalid when that shift step completes.
// A new request is taken only once the previous one has finished its shift
// step and the sequencer is back in idle.
// The result register parts the two sides: a request is accepted while the
// last result still waits; if the receiver stalls, the next request holds in
// its shift step until the result register frees up.
// Reset empties the cache (occupancy zero) and sets capacity to 16; the id
// storage needs no clearing pass.
module lru_id_cache (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lruc_pkg::IN_TDATA_W-1:0]  s_tdata,   // req_id
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lruc_pkg::OUT_TDATA_W-1:0] m_tdata,   // hit, hit_rank, evict_valid, evict_id
    input  logic                             cfg_we,
    input  logic [lruc_pkg::CAP_W-1:0]       cfg_wdata
);

    localparam int N     = lruc_pkg::MAX_ENTRIES;
    localparam int IDW   = lruc_pkg::ID_WIDTH;
    localparam int OCCW  = lruc_pkg::OCC_W;
    localparam int IDXW  = lruc_pkg::IDX_W;
    localparam int CMP_W = (OCCW > lruc_pkg::CAP_W) ? OCCW : lruc_pkg::CAP_W;

    lruc_pkg::state_t                 state_reg, state_next;
    logic [lruc_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic [OCCW-1:0]                  occ_reg, occ_next;
    logic [IDW-1:0]                   req_reg, req_next;
    logic                             out_valid_reg, out_valid_next;
    logic [lruc_pkg::OUT_W-1:0]       out_data_reg, out_data_next;

    lruc_pkg::cell_ctrl_t             ctrl [N];
    logic [IDW-1:0]                   cell_id [N];
    logic [IDW-1:0]                   shift_in [N];
    logic [N:0]                       found;
    logic [N-1:0]                     first;

    logic [CMP_W-1:0]                 cap_ext;
    logic [OCCW-1:0]                  eff_cap;
    logic                             hit;
    logic [IDXW-1:0]                  rank;
    logic                             evict;
    logic [IDW-1:0]                   ev_id;
    logic [OCCW-1:0]                  limit;
    logic                             upd_go;

    // effective capacity
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
            eff_cap = OCCW'(1);
        else if (cap_ext > CMP_W'(N))
            eff_cap = OCCW'(N);
        else
            eff_cap = OCCW'(cap_ext);
    end

    // rank from the first-hit one-hot, evicted id from the occupancy
    always_comb
    begin
        rank  = '0;
        ev_id = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first[i])
                rank = rank | IDXW'(i);
            if (occ_reg == OCCW'(i + 1))
                ev_id = ev_id | cell_id[i];
        end
    end

    assign hit    = found[N];
    assign evict  = !hit && (occ_reg >= eff_cap);
    assign upd_go = (state_reg == lruc_pkg::ST_UPD) && (!out_valid_reg || m_tready);

    // deepest rank that takes its neighbor's id
    always_comb
    begin
        if (hit)
            limit = OCCW'(rank);
        else if (evict)
            limit = occ_reg - OCCW'(1);
        else
            limit = occ_reg;
    end

    // per-cell controls
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ctrl[i].cmp_en = (state_reg == lruc_pkg::ST_CMP);
            ctrl[i].valid  = (OCCW'(i) < occ_reg);
            ctrl[i].load   = upd_go && ((i == 0) || (OCCW'(i) <= limit));
        end
    end

    // cell row
    assign found[0] = 1'b0;
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign shift_in[g] = req_reg;
            end
            else
            begin : g_body
                assign shift_in[g] = cell_id[g-1];
            end

            lruc_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[g]),
                .req_id    (req_reg),
                .shift_in  (shift_in[g]),
                .found_in  (found[g]),
                .id        (cell_id[g]),
                .found_out (found[g+1]),
                .first     (first[g])
            );
        end
    endgenerate

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        occ_next       = occ_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            lruc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = IDW'(s_tdata[lruc_pkg::REQ_W-1:0]);
                    state_next = lruc_pkg::ST_CMP;
                end
            end
            lruc_pkg::ST_CMP:
            begin
                state_next = lruc_pkg::ST_UPD;
            end
            lruc_pkg::ST_UPD:
            begin
                if (upd_go)
                begin
                    if (!hit && !evict)
                        occ_next = occ_reg + OCCW'(1);
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[lruc_pkg::HIT_BIT] = hit;
                    out_data_next[lruc_pkg::RANK_LSB +: lruc_pkg::RANK_W] =
                        hit ? lruc_pkg::RANK_W'(rank) : '0;
                    out_data_next[lruc_pkg::EVV_BIT] = evict;
                    out_data_next[lruc_pkg::EVID_LSB +: lruc_pkg::EVID_W] =
                        evict ? lruc_pkg::EVID_W'(ev_id) : '0;
                    state_next = lruc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lruc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lruc_pkg::ST_IDLE;
            cap_reg       <= lruc_pkg::CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    // ports
    assign s_tready = (state_reg == lruc_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lruc_pkg::OUT_TDATA_W'(out_data_reg);

endmodule

// ===== hw/rtl/lruc_checker.sv =====
// port-level assertions for the lru id cache, bound to the top level
module lruc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lruc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // result shows once the compare and shift steps are through, after an accept into an empty result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |-> ##3 m_tvalid)
        else $error("result beat late");

    // a hit never evicts, a miss reports rank zero
    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[lruc_pkg::HIT_BIT]
            ? !m_tdata[lruc_pkg::EVV_BIT]
            : (m_tdata[lruc_pkg::RANK_LSB +: lruc_pkg::RANK_W] == '0)))
        else $error("hit and rank or evict fields disagree");

    // evicted id is zero when no entry is evicted
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[lruc_pkg::EVV_BIT])
            |-> (m_tdata[lruc_pkg::EVID_LSB +: lruc_pkg::EVID_W] == '0))
        else $error("evict id set without evict");

endmodule

bind lru_id_cache lruc_checker u_lruc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/lru_id_cache_tb.sv =====
// self-checking testbench for lru_id_cache with a scoreboard and stream drivers
module lru_id_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;
    localparam int POOL_MAX     = 24;
    localparam int PHASES       = 9;

    // one result beat, hit in the lowest bit
    typedef struct packed {
        logic [lruc_pkg::EVID_W-1:0] evict_id;
        logic                        evict_valid;
        logic [lruc_pkg::RANK_W-1:0] hit_rank;
        logic                        hit;
    } lru_result_t;

    // recency stack predictor and the queue of results it still owes
    class lru_scoreboard;
        logic [lruc_pkg::ID_WIDTH-1:0] stack [lruc_pkg::MAX_ENTRIES];
        int unsigned                   live;
        logic [lruc_pkg::CAP_W-1:0]    capacity;
        lru_result_t                   owed [$];
        int unsigned                   requests;
        int unsigned                   hits;
        int unsigned                   evictions;
        int unsigned                   errors;

        function new();
            live      = 0;
            capacity  = lruc_pkg::CAP_RESET;
            requests  = 0;
            hits      = 0;
            evictions = 0;
            errors    = 0;
        endfunction

        function void set_capacity(input logic [lruc_pkg::CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction

        // search, move to front or insert, evict the tail when over capacity
        function void note_request(input logic [lruc_pkg::ID_WIDTH-1:0] id);
            lru_result_t want;
            int          eff;
            int          n;
            int          pos;
            bit          found;
            eff   = int'(capacity);
            if (eff < 1) eff = 1;
            if (eff > lruc_pkg::MAX_ENTRIES) eff = lruc_pkg::MAX_ENTRIES;
            n     = int'(live);
            want  = '0;
            found = 1'b0;
            pos   = 0;
            for (int i = 0; i < n; i++) begin
                if (!found && stack[i] == id) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found) begin
                for (int i = pos; i > 0; i--) stack[i] = stack[i-1];
                want.hit      = 1'b1;
                want.hit_rank = lruc_pkg::RANK_W'(pos);
                hits++;
            end else if (n + 1 > eff) begin
                // tail leaves, occupancy stays where it was
                want.evict_valid = 1'b1;
                want.evict_id    = (n > 0) ? stack[n-1] : '0;
                for (int i = n - 1; i > 0; i--) stack[i] = stack[i-1];
                evictions++;
            end else begin
                for (int i = n; i > 0; i--) stack[i] = stack[i-1];
                n++;
            end
            stack[0] = id;
            live     = n;
            requests++;
            owed.push_back(want);
        endfunction

        // compare one output beat against the oldest owed result
        function void check_result(input logic [lruc_pkg::OUT_TDATA_W-1:0] beat);
            lru_result_t got;
            lru_result_t want;
            got.hit         = beat[lruc_pkg::HIT_BIT];
            got.hit_rank    = beat[lruc_pkg::RANK_LSB +: lruc_pkg::RANK_W];
            got.evict_valid = beat[lruc_pkg::EVV_BIT];
            got.evict_id    = beat[lruc_pkg::EVID_LSB +: lruc_pkg::EVID_W];
            if (owed.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"ERROR: result beat with nothing pending: ",
                              "hit=%0d rank=%0d ev=%0d id=%h"},
                             got.hit, got.hit_rank, got.evict_valid, got.evict_id);
                return;
            end
            want = owed.pop_front();
            if (got.hit !== want.hit || got.hit_rank !== want.hit_rank ||
                got.evict_valid !== want.evict_valid || got.evict_id !== want.evict_id) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"ERROR: at %0t exp hit=%0d rank=%0d ev=%0d id=%h, ",
                              "got hit=%0d rank=%0d ev=%0d id=%h"},
                             $realtime, want.hit, want.hit_rank, want.evict_valid,
                             want.evict_id, got.hit, got.hit_rank, got.evict_valid,
                             got.evict_id);
            end
        endfunction

        // anything still owed at the end is a failure
        function void close_out();
            if (owed.size() != 0) begin
                errors += owed.size();
                $display("ERROR: %0d results never arrived", owed.size());
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [lruc_pkg::IN_TDATA_W-1:0]  s_tdata;   // req_id
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lruc_pkg::OUT_TDATA_W-1:0] m_tdata;   // hit, hit_rank, evict_valid, evict_id
    logic                             cfg_we;
    logic [lruc_pkg::CAP_W-1:0]       cfg_wdata;

    lru_scoreboard sb;
    int            gap_pct;
    int            stall_pct;
    int            holdoff_cycles;
    int unsigned   cycle_count;

    // random phase plan: capacity, sender idle %, receiver stall %, beats, hold-off
    int ph_cap     [PHASES] = '{5, 9, 31, 17, 16, 3, 1, 12, 0};
    int ph_gap     [PHASES] = '{0, 61, 0, 9, 0, 0, 61, 0, 9};
    int ph_stall   [PHASES] = '{0, 0, 61, 9, 0, 0, 0, 61, 9};
    int ph_beats   [PHASES] = '{240, 240, 240, 240, 60, 240, 200, 200, 200};
    int ph_holdoff [PHASES] = '{0, 0, 0, 0, 150, 0, 0, 0, 0};

    lru_id_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: check at the rising edge, pick tready at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                m_tready <= 1'b0;
                holdoff_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one request beat with random idle cycles ahead of it
    task automatic send_req(input logic [lruc_pkg::ID_WIDTH-1:0] id);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        do @(posedge clk); while (!s_tready);
        sb.note_request(id);
        @(negedge clk);
    endtask

    // drop tvalid, let all results land, then a few quiet cycles
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // capacity write while the block is idle
    task automatic write_capacity(input logic [lruc_pkg::CAP_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_capacity(value);
    endtask

    initial
    begin
        logic [lruc_pkg::ID_WIDTH-1:0] pool [POOL_MAX];
        int                            eff;
        int                            pool_n;
        int                            roll;
        logic [lruc_pkg::ID_WIDTH-1:0] id;

        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        gap_pct        = 0;
        stall_pct      = 0;
        holdoff_cycles = 0;
        cycle_count    = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // capacity one: insert, hit, replace
        write_capacity(5'd1);
        send_req(16'h1234);
        send_req(16'h1234);
        send_req(16'h0000);
        send_req(16'h0000);
        // capacity zero acts as one
        write_capacity(5'd0);
        send_req(16'hFFFF);
        send_req(16'hFFFF);
        // capacity two: hit at rank one, then eviction
        write_capacity(5'd2);
        send_req(16'hAAAA);
        send_req(16'hFFFF);
        send_req(16'h5555);
        // full capacity: fill, evict the tail, hit at the deepest rank
        write_capacity(5'd16);
        for (int k = 0; k < 14; k++) send_req(16'h1 << k);
        send_req(16'h8000);
        send_req(16'h5555);

        // random phases over the capacity plan
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(ph_cap[p][lruc_pkg::CAP_W-1:0]);
            gap_pct        = ph_gap[p];
            stall_pct      = ph_stall[p];
            holdoff_cycles = ph_holdoff[p];
            eff = ph_cap[p];
            if (eff < 1) eff = 1;
            if (eff > lruc_pkg::MAX_ENTRIES) eff = lruc_pkg::MAX_ENTRIES;
            pool_n = eff + eff / 2 + 2;
            if (pool_n > POOL_MAX) pool_n = POOL_MAX;
            for (int i = 0; i < POOL_MAX; i++)
                pool[i] = lruc_pkg::ID_WIDTH'($urandom_range(16'hFFFF));
            for (int n = 0; n < ph_beats[p]; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    id = pool[$urandom_range(pool_n - 1)];
                else if (roll < 90)
                    id = lruc_pkg::ID_WIDTH'($urandom_range(16'hFFFF));
                else if (roll < 94)
                    id = 16'h0000;
                else if (roll < 97)
                    id = 16'hFFFF;
                else
                    id = 16'h1 << $urandom_range(15);
                send_req(id);
            end
        end

        // wrap up
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        $display("Ran %0d requests with %0d hits and %0d evictions",
                 sb.requests, sb.hits, sb.evictions);
        $display("Capacities from 0 up past 16 incl. lowering while full, plus one long output stall");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== lru_id_cache.f =====
hw/rtl/lruc_pkg.sv
hw/rtl/lruc_cell.sv
hw/rtl/lru_id_cache.sv
hw/rtl/lruc_checker.sv
test/lru_id_cache_tb.sv
